// ----- sv/dhoa_pkg.sv -----
package dhoa_pkg;

    localparam int CMD_BITS    = 2;
    localparam int KEY_IN_BITS = 32;
    localparam int HASH_BITS   = 10;
    localparam int STATUS_BITS = 2;
    localparam int IDX_BITS    = 10;
    localparam int CNT_BITS    = 11;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

    localparam int MARK_BITS = 2;
    localparam logic [MARK_BITS-1:0] MARK_EMPTY    = 2'd0;
    localparam logic [MARK_BITS-1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [MARK_BITS-1:0] MARK_VACATED  = 2'd2;

    localparam logic [CNT_BITS-1:0] SLOTS_RESET = 11'd1024;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mod_step;
        logic probe_chk;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic skip;
        logic chk_stop;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/dhoa_ram.sv -----
module dhoa_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dhoa_ctrl.sv -----
module dhoa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output dhoa_pkg::t_dp_cmd    o_cmd,
    input  dhoa_pkg::t_dp_status i_sts
);
    import dhoa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_CHK    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = i_sts.skip ? S_COMMIT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.probe_chk = 1'b1;
                n_state         = i_sts.chk_stop ? S_COMMIT : S_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- sv/dhoa_dp.sv -----
module dhoa_dp #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dhoa_pkg::t_dp_cmd                   i_cmd,
    output dhoa_pkg::t_dp_status                o_sts,
    input  logic                                i_cfg_valid,
    input  logic [dhoa_pkg::CNT_BITS-1:0]       i_cfg_data,
    input  logic [dhoa_pkg::CMD_BITS-1:0]       i_command,
    input  logic [dhoa_pkg::KEY_IN_BITS-1:0]    i_key,
    input  logic [dhoa_pkg::HASH_BITS-1:0]      i_probe_start,
    input  logic [dhoa_pkg::HASH_BITS-1:0]      i_probe_step,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [dhoa_pkg::STATUS_BITS-1:0]    o_status,
    output logic [dhoa_pkg::IDX_BITS-1:0]       o_slot_index,
    output logic [dhoa_pkg::CNT_BITS-1:0]       o_entries_now
);
    import dhoa_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int AW = CW + 1;
    localparam int WW = KEY_BITS + MARK_BITS;
    localparam int BW = $clog2(HASH_BITS);

    logic [CNT_BITS-1:0]  r_slots;
    logic [CW-1:0]        n_active;
    logic [CW-1:0]        r_n;
    logic [CMD_BITS-1:0]  r_cmd;
    logic [KEY_BITS-1:0]  r_key;
    logic [HASH_BITS-1:0] r_start_sh;
    logic [HASH_BITS-1:0] r_step_sh;
    logic [BW-1:0]        r_bit;
    logic [CW-1:0]        r_rem_a;
    logic [CW-1:0]        r_rem_b;
    logic [IW-1:0]        r_pos;
    logic [CW-1:0]        r_probe;
    logic                 r_hit;
    logic [IW-1:0]        r_hit_pos;
    logic                 r_free_seen;
    logic [IW-1:0]        r_free_pos;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_clr_addr;
    logic [STATUS_BITS-1:0] r_res_status;
    logic [IW-1:0]        r_res_slot;
    logic                 r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [IW-1:0]        r_out_slot;
    logic [CW-1:0]        r_out_count;

    logic [63:0]          key_wide;
    logic [CW:0]          sh_a;
    logic [CW:0]          sh_b;
    logic [CW:0]          n_ext;
    logic [CW-1:0]        rem_a_next;
    logic [CW-1:0]        rem_b_next;
    logic [AW-1:0]        pos_sum;
    logic [IW-1:0]        pos_next;
    logic [WW-1:0]        ram_rdata;
    logic [WW-1:0]        ram_wdata;
    logic [IW-1:0]        ram_addr;
    logic                 ram_we;
    logic [MARK_BITS-1:0] rd_mark;
    logic [KEY_BITS-1:0]  rd_key;
    logic                 rd_match;
    logic                 probe_last;
    logic                 is_insert;
    logic                 is_remove;
    logic                 cmd_known;
    logic [31:0]          slot_wide;
    logic [31:0]          count_wide;

    assign key_wide = {32'd0, i_key};

    always_comb begin
        if (r_slots == '0) begin
            n_active = CW'(1);
        end else if (32'(r_slots) > 32'(TABLE_SLOTS)) begin
            n_active = CW'(TABLE_SLOTS);
        end else begin
            n_active = CW'(r_slots);
        end
    end

    // Restoring remainder, one hash bit per cycle for both hash values.
    assign n_ext = {1'b0, r_n};
    assign sh_a  = {r_rem_a, r_start_sh[HASH_BITS-1]};
    assign sh_b  = {r_rem_b, r_step_sh[HASH_BITS-1]};
    assign rem_a_next = (sh_a >= n_ext) ? CW'(sh_a - n_ext) : CW'(sh_a);
    assign rem_b_next = (sh_b >= n_ext) ? CW'(sh_b - n_ext) : CW'(sh_b);

    always_comb begin
        pos_sum = AW'(r_pos) + AW'(r_rem_b);
        if (pos_sum >= AW'(r_n)) begin
            pos_sum = pos_sum - AW'(r_n);
        end
        pos_next = IW'(pos_sum);
    end

    assign rd_mark    = ram_rdata[WW-1 -: MARK_BITS];
    assign rd_key     = ram_rdata[KEY_BITS-1:0];
    assign rd_match   = (rd_mark == MARK_OCCUPIED) && (rd_key == r_key);
    assign probe_last = (r_probe == (r_n - CW'(1)));
    assign is_insert  = (r_cmd == CMD_INSERT);
    assign is_remove  = (r_cmd == CMD_REMOVE);
    assign cmd_known  = is_insert || is_remove || (r_cmd == CMD_LOOKUP);

    assign o_sts.clr_last = (r_clr_addr == IW'(TABLE_SLOTS - 1));
    assign o_sts.mod_last = (r_bit == '0);
    assign o_sts.skip     = !cmd_known || (is_insert && (r_count >= r_n));
    assign o_sts.chk_stop = (rd_mark == MARK_EMPTY) || rd_match || probe_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_pos;
        ram_wdata = {MARK_OCCUPIED, r_key};
        if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = {MARK_EMPTY, {KEY_BITS{1'b0}}};
        end else if (i_cmd.commit) begin
            if (is_insert) begin
                ram_we    = !r_hit && r_free_seen;
                ram_addr  = r_free_pos;
                ram_wdata = {MARK_OCCUPIED, r_key};
            end else if (is_remove) begin
                ram_we    = r_hit;
                ram_addr  = r_hit_pos;
                ram_wdata = {MARK_VACATED, r_key};
            end
        end
    end

    dhoa_ram #(
        .WIDTH(WW),
        .DEPTH(TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= SLOTS_RESET;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_slots <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (i_cmd.commit) begin
                if (is_insert && !r_hit && r_free_seen) begin
                    r_count <= r_count + CW'(1);
                end else if (is_remove && r_hit && (r_count != '0)) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n         <= n_active;
            r_cmd       <= i_command;
            r_key       <= key_wide[KEY_BITS-1:0];
            r_start_sh  <= i_probe_start;
            r_step_sh   <= i_probe_step;
            r_bit       <= BW'(HASH_BITS - 1);
            r_rem_a     <= '0;
            r_rem_b     <= '0;
            r_hit       <= 1'b0;
            r_free_seen <= 1'b0;
            r_hit_pos   <= '0;
            r_free_pos  <= '0;
        end
        if (i_cmd.mod_step) begin
            r_start_sh <= r_start_sh << 1;
            r_step_sh  <= r_step_sh << 1;
            r_rem_a    <= rem_a_next;
            r_rem_b    <= rem_b_next;
            r_bit      <= r_bit - BW'(1);
            r_pos      <= IW'(rem_a_next);
            r_probe    <= '0;
        end
        if (i_cmd.probe_chk) begin
            if (rd_match) begin
                r_hit     <= 1'b1;
                r_hit_pos <= r_pos;
            end
            if ((rd_mark != MARK_OCCUPIED) && !r_free_seen) begin
                r_free_seen <= 1'b1;
                r_free_pos  <= r_pos;
            end
            r_pos   <= pos_next;
            r_probe <= r_probe + CW'(1);
        end
        if (i_cmd.commit) begin
            unique case (r_cmd) inside
                CMD_INSERT: begin
                    if (r_hit) begin
                        r_res_status <= ST_DUPLICATE;
                        r_res_slot   <= '0;
                    end else if (r_free_seen) begin
                        r_res_status <= ST_DONE;
                        r_res_slot   <= r_free_pos;
                    end else begin
                        r_res_status <= ST_FULL;
                        r_res_slot   <= '0;
                    end
                end
                CMD_REMOVE, CMD_LOOKUP: begin
                    if (r_hit) begin
                        r_res_status <= ST_DONE;
                        r_res_slot   <= r_hit_pos;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_slot   <= '0;
                    end
                end
                default: begin
                    r_res_status <= ST_NOT_FOUND;
                    r_res_slot   <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_count  <= r_count;
        end
    end

    assign slot_wide  = 32'(r_out_slot);
    assign count_wide = 32'(r_out_count);

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_index  = slot_wide[IDX_BITS-1:0];
    assign o_entries_now = count_wide[CNT_BITS-1:0];

endmodule

// ----- sv/double_hash_open_address_table.sv -----
// Open-addressed key table with double hashing.
// Requests arrive on the input channel (i_in_valid / o_in_ready) with a command,
// a key and two hash values; each request gives exactly one result transfer on
// the output channel (o_out_valid / i_out_ready) with status, slot and count.
// The slot count register is written through its own channel
// (i_cfg_valid / o_cfg_ready), which is always ready; write it only while idle.
// Both hash values are reduced modulo the slot count by a bit-serial remainder
// unit, and each probe then passes through a read step and a check step on the
// single port slot memory with its registered read.
// o_out_valid rises after the remainder steps, the probes, a commit step and a
// response step; insert on a full table and unused commands skip the probes.
// o_in_ready rises together with o_out_valid as the result is loaded.
// One request is worked at a time; the next input transfer is taken once the
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds the block in its response step until taken.
// After reset the slot memory is cleared to empty, one slot per cycle, over
// all TABLE_SLOTS slots, during which o_in_ready stays low.
module double_hash_open_address_table #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dhoa_pkg::CNT_BITS-1:0]    i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [dhoa_pkg::CMD_BITS-1:0]    i_command,
    input  logic [dhoa_pkg::KEY_IN_BITS-1:0] i_key,
    input  logic [dhoa_pkg::HASH_BITS-1:0]   i_probe_start,
    input  logic [dhoa_pkg::HASH_BITS-1:0]   i_probe_step,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dhoa_pkg::STATUS_BITS-1:0] o_status,
    output logic [dhoa_pkg::IDX_BITS-1:0]    o_slot_index,
    output logic [dhoa_pkg::CNT_BITS-1:0]    o_entries_now
);
    import dhoa_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_sts;

    assign o_cfg_ready = 1'b1;

    dhoa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .o_cmd     (dp_cmd),
        .i_sts     (dp_sts)
    );

    dhoa_dp #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_probe_start(i_probe_start),
        .i_probe_step (i_probe_step),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_entries_now(o_entries_now)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input transfer taken while a request is in progress.");

    a_result_from_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.out_load))
        else $error("Result appeared without a load from the controller.");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_DUPLICATE || o_status == ST_FULL ||
            o_status == ST_NOT_FOUND)) |-> (o_slot_index == '0))
        else $error("Failed request reports a nonzero slot.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_entries_now) <= 32'(TABLE_SLOTS)))
        else $error("Entry count exceeds the table size.");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import dhoa_pkg::*;

    localparam int NUM_SLOTS = 1024;
    localparam int QUIET_LIMIT = 20000;
    localparam int POOL_DEPTH = 48;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [IDX_BITS-1:0]    slot;
        logic [CNT_BITS-1:0]    entries;
    } t_answer;

    typedef struct {
        logic [KEY_IN_BITS-1:0] key;
        logic [HASH_BITS-1:0]   start_h;
        logic [HASH_BITS-1:0]   step_h;
    } t_key_rec;

    class hash_table_shadow;
        logic [MARK_BITS-1:0]   mark [NUM_SLOTS];
        logic [KEY_IN_BITS-1:0] stored_key [NUM_SLOTS];
        int unsigned            occupied;
        logic [CNT_BITS-1:0]    slots_cfg;
        t_answer                answers_due [$];
        int unsigned            mismatches;

        function new();
            foreach (mark[i]) begin
                mark[i] = MARK_EMPTY;
                stored_key[i] = '0;
            end
            occupied = 0;
            slots_cfg = SLOTS_RESET;
            mismatches = 0;
        endfunction

        function int unsigned live_slots();
            if (slots_cfg == 0) begin
                return 1;
            end
            if (slots_cfg > NUM_SLOTS) begin
                return NUM_SLOTS;
            end
            return slots_cfg;
        endfunction

        // Walks the probe path; empty ends the search, vacated slots are skipped.
        function bit locate(logic [KEY_IN_BITS-1:0] key, int unsigned origin,
                            int unsigned stride, int unsigned n,
                            output int unsigned where);
            int unsigned pos;
            pos = origin;
            where = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (mark[pos] == MARK_EMPTY) begin
                    return 0;
                end
                if (mark[pos] == MARK_OCCUPIED && stored_key[pos] == key) begin
                    where = pos;
                    return 1;
                end
                pos += stride;
                if (pos >= n) begin
                    pos -= n;
                end
            end
            return 0;
        endfunction

        function void note_request(logic [CMD_BITS-1:0] cmd, logic [KEY_IN_BITS-1:0] key,
                                   logic [HASH_BITS-1:0] start_h,
                                   logic [HASH_BITS-1:0] step_h);
            int unsigned n;
            int unsigned origin;
            int unsigned stride;
            int unsigned pos;
            int unsigned where;
            t_answer     ans;
            n = live_slots();
            origin = start_h % n;
            stride = step_h % n;
            ans.status = ST_NOT_FOUND;
            ans.slot = '0;
            case (cmd)
                CMD_INSERT: begin
                    if (occupied >= n) begin
                        ans.status = ST_FULL;
                    end else if (locate(key, origin, stride, n, where)) begin
                        ans.status = ST_DUPLICATE;
                    end else begin
                        ans.status = ST_FULL;
                        pos = origin;
                        for (int unsigned i = 0; i < n; i++) begin
                            if (mark[pos] != MARK_OCCUPIED) begin
                                mark[pos] = MARK_OCCUPIED;
                                stored_key[pos] = key;
                                occupied++;
                                ans.status = ST_DONE;
                                ans.slot = IDX_BITS'(pos);
                                break;
                            end
                            pos += stride;
                            if (pos >= n) begin
                                pos -= n;
                            end
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (locate(key, origin, stride, n, where)) begin
                        mark[where] = MARK_VACATED;
                        if (occupied > 0) begin
                            occupied--;
                        end
                        ans.status = ST_DONE;
                        ans.slot = IDX_BITS'(where);
                    end
                end
                CMD_LOOKUP: begin
                    if (locate(key, origin, stride, n, where)) begin
                        ans.status = ST_DONE;
                        ans.slot = IDX_BITS'(where);
                    end
                end
                default: begin
                end
            endcase
            ans.entries = CNT_BITS'(occupied);
            answers_due.push_back(ans);
        endfunction

        function void check_response(logic [STATUS_BITS-1:0] status,
                                     logic [IDX_BITS-1:0] slot,
                                     logic [CNT_BITS-1:0] entries);
            t_answer want;
            if (answers_due.size() == 0) begin
                $error("result transfer with no request pending: status %0d slot %0d entries %0d",
                       status, slot, entries);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (slot !== want.slot) begin
                $error("slot_index: expected %0d, actual %0d", want.slot, slot);
                mismatches++;
            end
            if (entries !== want.entries) begin
                $error("entries_now: expected %0d, actual %0d", want.entries, entries);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_BITS-1:0]    i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CMD_BITS-1:0]    i_command = CMD_INSERT;
    logic [KEY_IN_BITS-1:0] i_key = '0;
    logic [HASH_BITS-1:0]   i_probe_start = '0;
    logic [HASH_BITS-1:0]   i_probe_step = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [STATUS_BITS-1:0] o_status;
    logic [IDX_BITS-1:0]    o_slot_index;
    logic [CNT_BITS-1:0]    o_entries_now;

    hash_table_shadow sb;
    int unsigned      ready_mode = 0;
    int unsigned      mode_left = 0;
    int unsigned      stall_left = 0;
    int unsigned      quiet_cycles = 0;
    int               phase_slots [10] = '{1, 0, 4, 2, 7, 2047, 37, 13, 1000, 1024};

    double_hash_open_address_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_probe_start (i_probe_start),
        .i_probe_step  (i_probe_step),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_entries_now (o_entries_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (ready_mode == 0) begin
            i_out_ready <= 1'b1;
        end else if (ready_mode == 1) begin
            i_out_ready <= 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(1, 30);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            sb.check_response(o_status, o_slot_index, o_entries_now);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input logic [CMD_BITS-1:0] cmd, input logic [KEY_IN_BITS-1:0] key,
                            input logic [HASH_BITS-1:0] start_h,
                            input logic [HASH_BITS-1:0] step_h);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key <= key;
        i_probe_start <= start_h;
        i_probe_step <= step_h;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(cmd, key, start_h, step_h);
    endtask

    task automatic pause_sender(input int unsigned gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        pause_sender(1);
        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_slots(input logic [CNT_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.slots_cfg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Each occupied slot is removed through a probe path that starts on it.
    task automatic drain_table();
        for (int unsigned s = 0; s < sb.live_slots(); s++) begin
            if (sb.mark[s] == MARK_OCCUPIED) begin
                send_req(CMD_REMOVE, sb.stored_key[s], HASH_BITS'(s), '0);
            end
        end
        settle();
    endtask

    // Most requests reuse keys and hash pairs that were inserted earlier, so
    // lookups, removes and duplicate inserts actually meet their entries.
    task automatic random_items(input int unsigned count);
        t_key_rec               pool [$];
        t_key_rec               rec;
        int unsigned            burst;
        int unsigned            sel;
        logic [CMD_BITS-1:0]    cmd;
        logic [KEY_IN_BITS-1:0] key;
        logic [HASH_BITS-1:0]   sh;
        logic [HASH_BITS-1:0]   st;
        burst = 0;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 1) == 1) begin
                    pause_sender($urandom_range(1, 10));
                end
            end
            burst--;
            sel = $urandom_range(0, 99);
            if (pool.size() == 0 || sel < 40) begin
                cmd = CMD_INSERT;
                key = $urandom;
                sh = HASH_BITS'($urandom);
                st = HASH_BITS'($urandom);
                rec.key = key;
                rec.start_h = sh;
                rec.step_h = st;
                pool.push_back(rec);
                if (pool.size() > POOL_DEPTH) begin
                    void'(pool.pop_front());
                end
            end else begin
                rec = pool[$urandom_range(0, pool.size() - 1)];
                key = rec.key;
                sh = rec.start_h;
                st = rec.step_h;
                if (sel < 52) begin
                    cmd = CMD_INSERT;
                end else if (sel < 75) begin
                    cmd = CMD_LOOKUP;
                end else if (sel < 92) begin
                    cmd = CMD_REMOVE;
                end else if (sel < 97) begin
                    cmd = ($urandom_range(0, 1) == 1) ? CMD_LOOKUP : CMD_REMOVE;
                    key = $urandom;
                end else begin
                    cmd = CMD_UNUSED;
                end
            end
            send_req(cmd, key, sh, st);
        end
        settle();
    endtask

    initial begin
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);

        // Full size table: empty misses, duplicates found across the wrap,
        // a zero stride that exhausts its probes, and reuse of a vacated slot.
        send_req(CMD_LOOKUP, 32'h0, 10'd0, 10'd0);
        send_req(CMD_REMOVE, 32'h0, 10'd0, 10'd0);
        send_req(CMD_INSERT, 32'h0, 10'd0, 10'd0);
        send_req(CMD_INSERT, 32'h0, 10'd0, 10'd0);
        send_req(CMD_INSERT, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
        send_req(CMD_INSERT, 32'hFFFF_FFFF, 10'd0, 10'd1023);
        send_req(CMD_INSERT, 32'h5, 10'd0, 10'd0);
        send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 10'd1023, 10'd0);
        send_req(CMD_REMOVE, 32'h0, 10'd0, 10'd5);
        send_req(CMD_LOOKUP, 32'h0, 10'd0, 10'd1);
        send_req(CMD_INSERT, 32'h7, 10'd0, 10'd1);
        send_req(CMD_UNUSED, 32'h1234_5678, 10'd3, 10'd9);
        send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 10'd0, 10'd1023);
        settle();
        drain_table();
        random_items(130);
        drain_table();

        foreach (phase_slots[p]) begin
            set_slots(CNT_BITS'(phase_slots[p]));
            if (phase_slots[p] == 1) begin
                send_req(CMD_INSERT, 32'hA5A5_A5A5, 10'd1023, 10'd1023);
                send_req(CMD_INSERT, 32'h5A5A_5A5A, 10'd0, 10'd0);
                send_req(CMD_LOOKUP, 32'hA5A5_A5A5, 10'd17, 10'd300);
                send_req(CMD_REMOVE, 32'h5A5A_5A5A, 10'd0, 10'd0);
                send_req(CMD_REMOVE, 32'hA5A5_A5A5, 10'd0, 10'd0);
                send_req(CMD_LOOKUP, 32'hA5A5_A5A5, 10'd0, 10'd0);
            end
            if (phase_slots[p] == 4) begin
                // A stride of two on four slots never sees the odd slots.
                send_req(CMD_INSERT, 32'h11, 10'd0, 10'd2);
                send_req(CMD_INSERT, 32'h22, 10'd0, 10'd2);
                send_req(CMD_INSERT, 32'h33, 10'd4, 10'd6);
                send_req(CMD_LOOKUP, 32'h33, 10'd0, 10'd3);
            end
            random_items(125);
            drain_table();
        end

        if (sb.mismatches == 0 && sb.answers_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dhoa_pkg.sv
sv/dhoa_ram.sv
sv/dhoa_ctrl.sv
sv/dhoa_dp.sv
sv/double_hash_open_address_table.sv
dv/tb.sv
